### hw/rtl/idw_pkg.sv
// Shared types and constants for the inverse distance weighting block.
`timescale 1ns / 1ps

package idw_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int DIST_W     = 18;
    localparam int SQ_W       = 36;
    localparam int RECIP_W    = 33;
    localparam int TOTAL_W    = 39;
    localparam int WEIGHT_W   = 17;

    localparam logic [0:0] CMD_LOAD  = 1'b0;
    localparam logic [0:0] CMD_QUERY = 1'b1;

    localparam logic [0:0] REG_NEIGHBOR_COUNT = 1'b0;
    localparam logic [0:0] REG_POINT_COUNT    = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  entry_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic signed [31:0] entry_value;
    } idw_in_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [16:0] weight;
        logic [5:0]  rank;
        logic        last;
    } idw_out_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             load_write;
        logic             dist_start;
        logic [IDX_W-1:0] dist_idx;
        logic             sel_clear;
        logic             sel_step;
        logic [IDX_W-1:0] sel_idx;
        logic             sel_commit;
        logic [IDX_W-1:0] sel_rank;
        logic             div_start;
        logic             div_weight;
        logic [IDX_W-1:0] div_rank;
        logic [IDX_W-1:0] rd_rank;
        logic             total_clear;
        logic             out_load;
        logic [IDX_W-1:0] out_rank;
        logic             out_last;
        logic             out_single;
    } idw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic dist_done;
        logic div_done;
        logic first_zero;
    } idw_sts_t;

endpackage

### hw/rtl/idw_datapath.sv
// Datapath: point store, distance unit, selection scan, shared divider, output register.
`timescale 1ns / 1ps

module idw_datapath import idw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  idw_in_t  s_data,
    input  idw_cmd_t cmd,
    output idw_sts_t sts,
    output idw_out_t res_data
);

    logic [47:0] coord_mem [MAX_POINTS];
    logic [31:0] value_mem [MAX_POINTS];
    logic [47:0] coord_rd_reg;
    logic [31:0] value_rd_reg;

    logic signed [15:0] qx_reg, qy_reg, qz_reg;
    logic [DIST_W-1:0] dist_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] used_reg;
    logic [IDX_W-1:0] order_mem [MAX_POINTS];
    logic [DIST_W-1:0] odist_mem [MAX_POINTS];
    logic [RECIP_W-1:0] recip_mem [MAX_POINTS];
    logic [IDX_W-1:0] ord_rd_reg;
    logic [DIST_W-1:0] odist_rd_reg;
    logic [RECIP_W-1:0] recip_rd_reg;

    // distance: read, square, sum, then 18-step square root
    logic [1:0]  dphase_reg;
    logic [IDX_W-1:0] didx_reg;
    logic [SQ_W-1:0] sq_reg;
    logic [SQ_W-1:0] rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [4:0]  rstep_reg;
    logic        dbusy_reg;
    logic        ddone_reg;
    logic [33:0] sqx_reg, sqy_reg, sqz_reg;

    logic signed [16:0] dx, dy, dz;
    logic [16:0] ax, ay, az;
    logic [SQ_W+1:0] trial;
    logic [SQ_W+1:0] rem_sh;

    always_ff @(posedge aclk) begin
        if (cmd.load_write) begin
            coord_mem[s_data.entry_index] <= {s_data.coord_z, s_data.coord_y, s_data.coord_x};
            value_mem[s_data.entry_index] <= s_data.entry_value;
        end
        if (cmd.dist_start)
            coord_rd_reg <= coord_mem[cmd.dist_idx];
        value_rd_reg <= value_mem[ord_rd_reg];
        if (cmd.capture) begin
            qx_reg <= s_data.coord_x;
            qy_reg <= s_data.coord_y;
            qz_reg <= s_data.coord_z;
        end
    end

    assign dx = 17'(signed'(qx_reg)) - 17'(signed'(coord_rd_reg[15:0]));
    assign dy = 17'(signed'(qy_reg)) - 17'(signed'(coord_rd_reg[31:16]));
    assign dz = 17'(signed'(qz_reg)) - 17'(signed'(coord_rd_reg[47:32]));
    assign ax = dx[16] ? 17'(-dx) : 17'(dx);
    assign ay = dy[16] ? 17'(-dy) : 17'(dy);
    assign az = dz[16] ? 17'(-dz) : 17'(dz);

    assign rem_sh = {rem_reg, 2'b00} | (SQ_W+2)'(sq_reg[SQ_W-1 -: 2]);
    assign trial  = (SQ_W+2)'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dphase_reg <= 2'd0;
        end else begin
            ddone_reg <= 1'b0;
            if (cmd.dist_start) begin
                dbusy_reg  <= 1'b1;
                dphase_reg <= 2'd0;
                didx_reg   <= cmd.dist_idx;
            end else if (dbusy_reg) begin
                unique case (dphase_reg)
                    2'd0: dphase_reg <= 2'd1;
                    2'd1: begin
                        sqx_reg <= 34'(ax) * 34'(ax);
                        sqy_reg <= 34'(ay) * 34'(ay);
                        sqz_reg <= 34'(az) * 34'(az);
                        dphase_reg <= 2'd2;
                    end
                    2'd2: begin
                        sq_reg    <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg) + SQ_W'(sqz_reg);
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        rstep_reg <= 5'd0;
                        dphase_reg <= 2'd3;
                    end
                    default: begin
                        if (rem_sh >= trial) begin
                            rem_reg  <= SQ_W'(rem_sh - trial);
                            root_reg <= {root_reg[DIST_W-2:0], 1'b1};
                        end else begin
                            rem_reg  <= SQ_W'(rem_sh);
                            root_reg <= {root_reg[DIST_W-2:0], 1'b0};
                        end
                        sq_reg <= {sq_reg[SQ_W-3:0], 2'b00};
                        if (rstep_reg == 5'd17) begin
                            dbusy_reg <= 1'b0;
                            ddone_reg <= 1'b1;
                        end
                        rstep_reg <= rstep_reg + 5'd1;
                    end
                endcase
            end
        end
    end

    // selection scan: one candidate per cycle, each read into a register and then compared
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              best_ok_reg;
    logic [DIST_W-1:0] cand_reg;
    logic [IDX_W-1:0]  cidx_reg;
    logic              cval_reg;
    logic [DIST_W-1:0] first_dist_reg;

    logic [DIST_W-1:0] last_root;
    assign last_root = (rem_sh >= trial) ? {root_reg[DIST_W-2:0], 1'b1}
                                         : {root_reg[DIST_W-2:0], 1'b0};
    always_ff @(posedge aclk) begin
        if (dbusy_reg && dphase_reg == 2'd3 && rstep_reg == 5'd17)
            dist_mem[didx_reg] <= last_root;
        cand_reg <= dist_mem[cmd.sel_idx];
        cidx_reg <= cmd.sel_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            best_ok_reg <= 1'b0;
            cval_reg    <= 1'b0;
        end else begin
            cval_reg <= cmd.sel_step;
            if (cmd.capture)
                used_reg <= '0;
            if (cmd.sel_clear)
                best_ok_reg <= 1'b0;
            else if (cval_reg && !used_reg[cidx_reg] &&
                     (!best_ok_reg || cand_reg < best_dist_reg)) begin
                best_ok_reg   <= 1'b1;
                best_dist_reg <= cand_reg;
                best_idx_reg  <= cidx_reg;
            end
            if (cmd.sel_commit) begin
                used_reg[best_idx_reg]  <= 1'b1;
                order_mem[cmd.sel_rank] <= best_idx_reg;
                odist_mem[cmd.sel_rank] <= best_dist_reg;
                if (cmd.sel_rank == '0)
                    first_dist_reg <= best_dist_reg;
            end
        end
    end
    assign sts.first_zero = (first_dist_reg == '0);

    // restoring divider shared by reciprocals and weights
    logic [TOTAL_W-1:0] total_reg;
    logic [48:0] dvd_reg;
    logic [TOTAL_W-1:0] dvs_reg;
    logic [TOTAL_W:0]   drem_reg;
    logic [48:0]        quo_reg;
    logic [5:0]         dcnt_reg;
    logic               dbusy2_reg, ddone2_reg, dweight_reg;
    logic [IDX_W-1:0]   drank_reg;
    logic [TOTAL_W:0]   drem_sh;
    assign drem_sh = {drem_reg[TOTAL_W-1:0], dvd_reg[48]};

    always_ff @(posedge aclk) begin
        ord_rd_reg   <= order_mem[cmd.out_rank];
        odist_rd_reg <= (cmd.sel_commit && cmd.sel_rank == cmd.rd_rank) ? best_dist_reg
                                                                        : odist_mem[cmd.rd_rank];
        recip_rd_reg <= (ddone2_reg && !dweight_reg && drank_reg == cmd.rd_rank) ?
                        quo_reg[RECIP_W-1:0] : recip_mem[cmd.rd_rank];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy2_reg <= 1'b0;
            ddone2_reg <= 1'b0;
        end else begin
            ddone2_reg <= 1'b0;
            if (cmd.total_clear)
                total_reg <= '0;
            if (cmd.div_start) begin
                dbusy2_reg  <= 1'b1;
                dweight_reg <= cmd.div_weight;
                drank_reg   <= cmd.div_rank;
                drem_reg    <= '0;
                quo_reg     <= '0;
                dcnt_reg    <= 6'd0;
                if (cmd.div_weight) begin
                    dvd_reg <= {recip_rd_reg, 16'h0000};
                    dvs_reg <= total_reg;
                end else begin
                    dvd_reg <= 49'(64'h1_0000_0000);
                    dvs_reg <= TOTAL_W'(odist_rd_reg);
                end
            end else if (dbusy2_reg) begin
                if (drem_sh >= {1'b0, dvs_reg}) begin
                    drem_reg <= drem_sh - {1'b0, dvs_reg};
                    quo_reg  <= {quo_reg[47:0], 1'b1};
                end else begin
                    drem_reg <= drem_sh;
                    quo_reg  <= {quo_reg[47:0], 1'b0};
                end
                dvd_reg  <= {dvd_reg[47:0], 1'b0};
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd48) begin
                    dbusy2_reg <= 1'b0;
                    ddone2_reg <= 1'b1;
                end
            end
            if (ddone2_reg && !dweight_reg)
                total_reg <= total_reg + TOTAL_W'(quo_reg[RECIP_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ddone2_reg && !dweight_reg)
            recip_mem[drank_reg] <= quo_reg[RECIP_W-1:0];
    end

    assign sts.dist_done = ddone_reg;
    assign sts.div_done  = ddone2_reg;

    logic [WEIGHT_W-1:0] w_reg;
    always_ff @(posedge aclk) begin
        if (ddone2_reg && dweight_reg)
            w_reg <= quo_reg[WEIGHT_W-1:0];
    end

    idw_out_t out_reg;
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.sample_value <= value_rd_reg;
            out_reg.weight       <= cmd.out_single ? 17'h10000 : w_reg;
            out_reg.rank         <= cmd.out_rank;
            out_reg.last         <= cmd.out_last;
        end
    end
    assign res_data = out_reg;

endmodule

### hw/rtl/idw_ctrl.sv
// Controller state machine sequencing distance, selection, weighting and output.
`timescale 1ns / 1ps

module idw_ctrl import idw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_cmd,
    input  logic [CNT_W-1:0] n_eff,
    input  logic [CNT_W-1:0] k_eff,
    output logic     m_valid,
    input  logic     m_ready,
    input  idw_sts_t sts,
    output idw_cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_DIST  = 11'b000_0000_0010,
        ST_DWAIT = 11'b000_0000_0100,
        ST_SCAN  = 11'b000_0000_1000,
        ST_PICK  = 11'b000_0001_0000,
        ST_RECIP = 11'b000_0010_0000,
        ST_RWAIT = 11'b000_0100_0000,
        ST_WDIV  = 11'b000_1000_0000,
        ST_WWAIT = 11'b001_0000_0000,
        ST_OUT   = 11'b010_0000_0000,
        ST_SWAIT = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] n_reg, k_reg;
    logic single_reg, single_next;
    logic ovalid_reg, ovalid_next;
    logic [1:0] rd_reg, rd_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        r_next      = r_reg;
        single_next = single_reg;
        ovalid_next = ovalid_reg;
        rd_next     = rd_reg;
        cmd         = '0;
        cmd.dist_idx = i_reg[IDX_W-1:0];
        cmd.sel_idx  = i_reg[IDX_W-1:0];
        cmd.sel_rank = r_reg[IDX_W-1:0];
        cmd.div_rank = r_reg[IDX_W-1:0];
        cmd.out_rank = single_reg ? '0 : r_reg[IDX_W-1:0];
        cmd.out_single = single_reg;
        if (ovalid_reg && m_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_cmd == CMD_LOAD) begin
                        cmd.load_write = 1'b1;
                    end else if (n_eff != '0) begin
                        cmd.capture = 1'b1;
                        i_next = '0;
                        r_next = '0;
                        single_next = 1'b0;
                        state_next = ST_DIST;
                    end
                end
            end
            ST_DIST: begin
                cmd.dist_start = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (sts.dist_done) begin
                    if (i_reg == n_reg - 7'd1) begin
                        i_next = '0;
                        cmd.sel_clear = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        i_next = i_reg + 7'd1;
                        state_next = ST_DIST;
                    end
                end
            end
            ST_SCAN: begin
                cmd.sel_step = 1'b1;
                if (i_reg == n_reg - 7'd1)
                    state_next = ST_SWAIT;
                else
                    i_next = i_reg + 7'd1;
            end
            ST_SWAIT: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                cmd.sel_commit = 1'b1;
                i_next = '0;
                if (r_reg == k_reg - 7'd1) begin
                    r_next = '0;
                    cmd.total_clear = 1'b1;
                    state_next = ST_RECIP;
                end else begin
                    r_next = r_reg + 7'd1;
                    cmd.sel_clear = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_RECIP: begin
                if (sts.first_zero) begin
                    single_next = 1'b1;
                    rd_next = 2'd0;
                    state_next = ST_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next = ST_RWAIT;
                end
            end
            ST_RWAIT: begin
                if (sts.div_done) begin
                    if (r_reg == k_reg - 7'd1) begin
                        r_next = '0;
                        state_next = ST_WDIV;
                    end else begin
                        r_next = r_reg + 7'd1;
                        state_next = ST_RECIP;
                    end
                end
            end
            ST_WDIV: begin
                cmd.div_start  = 1'b1;
                cmd.div_weight = 1'b1;
                state_next = ST_WWAIT;
            end
            ST_WWAIT: begin
                if (sts.div_done) begin
                    rd_next = 2'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // let the value read settle, then load the output register
                if (rd_reg != 2'd2) begin
                    rd_next = rd_reg + 2'd1;
                end else if (!ovalid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = single_reg || (r_reg == k_reg - 7'd1);
                    ovalid_next = 1'b1;
                    if (cmd.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        r_next = r_reg + 7'd1;
                        state_next = ST_WDIV;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.rd_rank = r_next[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
            r_reg      <= '0;
            single_reg <= 1'b0;
            rd_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            i_reg      <= i_next;
            r_reg      <= r_next;
            single_reg <= single_next;
            rd_reg     <= rd_next;
        end
        if (cmd.capture) begin
            n_reg <= n_eff;
            k_reg <= k_eff;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_DIST && state_reg != ST_DWAIT)
        |-> r_reg < k_reg) else $error("rank beyond k");

endmodule

### hw/rtl/inverse_distance_weights.sv
// Top level of the inverse distance weighting block: config registers, controller, datapath.
`timescale 1ns / 1ps
// Channel  | Ports                          | Beat
// input    | s_valid s_ready s_data         | load or query item
// result   | m_valid m_ready m_data         | one weighted neighbor
// config   | cfg_we cfg_index cfg_data      | one register write
// Query: accept, then distances for every stored point (18-step root), the
// nearest-neighbor scan for each of the k neighbors, then reciprocals per
// neighbor and weights with output beats per neighbor in the 49-step divider;
// a coincident point ends with a single beat after the scan. A load is written when accepted.
// Reset (aresetn low, synchronous) clears control state; table contents are
// undefined until loaded. A stalled result holds the next output beat.

module inverse_distance_weights import idw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  idw_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output idw_out_t    m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    logic [CNT_W-1:0] neighbor_count_reg, point_count_reg;
    logic [CNT_W-1:0] n_eff, k_eff;
    idw_cmd_t cmd;
    idw_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neighbor_count_reg <= '0;
            point_count_reg    <= 7'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_NEIGHBOR_COUNT: neighbor_count_reg <= cfg_data;
                REG_POINT_COUNT:    point_count_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign n_eff = (point_count_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : point_count_reg;
    assign k_eff = (neighbor_count_reg == '0 || neighbor_count_reg > n_eff) ? n_eff
                                                                          : neighbor_count_reg;

    idw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_data.cmd),
        .n_eff   (n_eff),
        .k_eff   (k_eff),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    idw_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (m_data)
    );

endmodule
